/* rtl/lnc_pkg.sv */
package lnc_pkg;

    // command codes carried by each input item
    typedef enum logic [1:0] {
        CMD_WRITE  = 2'd0,
        CMD_TIMER  = 2'd1,
        CMD_ENV    = 2'd2,
        CMD_LENGTH = 2'd3
    } t_cmd;

    // register numbers
    localparam logic [1:0] REG_CTRL   = 2'd0;
    localparam logic [1:0] REG_SWEEP  = 2'd1;
    localparam logic [1:0] REG_PERIOD = 2'd2;
    localparam logic [1:0] REG_LENGTH = 2'd3;

    localparam int         NUM_REGS      = 4;
    localparam logic [3:0] LEVEL_MAX     = 4'hF;
    localparam logic [11:0] PERIOD_MIN   = 12'd8;
    localparam logic [14:0] LFSR_SEED    = 15'd1;

    // one input item as it travels between stages
    typedef struct packed {
        logic [1:0] cmd;
        logic [1:0] reg_select;
        logic [7:0] write_byte;
    } t_item;

    // timer reload values
    function automatic logic [11:0] period_of(input logic [3:0] idx);
        logic [11:0] val;
        case (idx)
            4'd0:    val = 12'd4;
            4'd1:    val = 12'd8;
            4'd2:    val = 12'd16;
            4'd3:    val = 12'd32;
            4'd4:    val = 12'd64;
            4'd5:    val = 12'd96;
            4'd6:    val = 12'd128;
            4'd7:    val = 12'd160;
            4'd8:    val = 12'd202;
            4'd9:    val = 12'd254;
            4'd10:   val = 12'd380;
            4'd11:   val = 12'd508;
            4'd12:   val = 12'd762;
            4'd13:   val = 12'd1016;
            4'd14:   val = 12'd2034;
            4'd15:   val = 12'd4068;
            default: val = 12'd4;
        endcase
        return val;
    endfunction

    // length counter load values
    function automatic logic [7:0] length_of(input logic [4:0] idx);
        logic [7:0] val;
        case (idx)
            5'd0:    val = 8'd10;
            5'd1:    val = 8'd254;
            5'd2:    val = 8'd20;
            5'd3:    val = 8'd2;
            5'd4:    val = 8'd40;
            5'd5:    val = 8'd4;
            5'd6:    val = 8'd80;
            5'd7:    val = 8'd6;
            5'd8:    val = 8'd160;
            5'd9:    val = 8'd8;
            5'd10:   val = 8'd60;
            5'd11:   val = 8'd10;
            5'd12:   val = 8'd14;
            5'd13:   val = 8'd12;
            5'd14:   val = 8'd26;
            5'd15:   val = 8'd14;
            5'd16:   val = 8'd12;
            5'd17:   val = 8'd16;
            5'd18:   val = 8'd24;
            5'd19:   val = 8'd18;
            5'd20:   val = 8'd48;
            5'd21:   val = 8'd20;
            5'd22:   val = 8'd96;
            5'd23:   val = 8'd22;
            5'd24:   val = 8'd192;
            5'd25:   val = 8'd24;
            5'd26:   val = 8'd72;
            5'd27:   val = 8'd26;
            5'd28:   val = 8'd16;
            5'd29:   val = 8'd28;
            5'd30:   val = 8'd32;
            5'd31:   val = 8'd30;
            default: val = 8'd10;
        endcase
        return val;
    endfunction

endpackage

/* rtl/lnc_if.sv */
// command channel
interface lnc_in_if import lnc_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic [1:0] reg_select;
    logic [7:0] write_byte;

    modport source (output valid, output cmd, output reg_select, output write_byte,
                    input ready);
    modport sink   (input valid, input cmd, input reg_select, input write_byte,
                    output ready);
endinterface

// amplitude channel
interface lnc_out_if import lnc_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [3:0] amplitude;

    modport source (output valid, output amplitude, input ready);
    modport sink   (input valid, input amplitude, output ready);
endinterface

/* rtl/lnc_in_stage.sv */
module lnc_in_stage import lnc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lnc_in_if.sink      i_in,
    input  logic        i_take,
    output logic        o_valid,
    output t_item       o_item
);

    logic  r_valid;
    logic  n_valid;
    t_item r_item;
    logic  w_accept;
    logic  w_fire;

    // room when empty or when the held item moves on this cycle
    assign w_fire     = r_valid && i_take;
    assign i_in.ready = i_rst_n && (!r_valid || i_take);
    assign w_accept   = i_in.valid && i_in.ready;

    // valid flag
    always_comb begin
        n_valid = r_valid;
        if (w_accept) begin
            n_valid = 1'b1;
        end else if (w_fire) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // payload capture
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= '{cmd: i_in.cmd, reg_select: i_in.reg_select,
                        write_byte: i_in.write_byte};
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

/* rtl/lnc_core.sv */
module lnc_core import lnc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  t_item       i_item,
    output logic [3:0]  o_amplitude
);

    logic [7:0]  r_regs [NUM_REGS];
    logic [7:0]  n_regs [NUM_REGS];
    logic [11:0] r_reload, n_reload;
    logic [11:0] r_count, n_count;
    logic [14:0] r_lfsr, n_lfsr;
    logic [7:0]  r_len, n_len;
    logic        r_restart, n_restart;
    logic [3:0]  r_env_level, n_env_level;
    logic [3:0]  r_env_count, n_env_count;

    logic [3:0]  w_vol;
    logic        w_halt;
    logic        w_tap;
    logic        w_mute;

    assign w_vol   = r_regs[REG_CTRL][3:0];
    assign w_halt  = r_regs[REG_CTRL][5];
    assign w_tap   = r_regs[REG_PERIOD][7] ? r_lfsr[6] : r_lfsr[1];

    // next state for the command
    always_comb begin
        n_regs      = r_regs;
        n_reload    = r_reload;
        n_count     = r_count;
        n_lfsr      = r_lfsr;
        n_len       = r_len;
        n_restart   = r_restart;
        n_env_level = r_env_level;
        n_env_count = r_env_count;
        case (t_cmd'(i_item.cmd))
            CMD_WRITE: begin
                n_regs[i_item.reg_select] = i_item.write_byte;
                case (i_item.reg_select)
                    REG_CTRL:   n_restart = 1'b1;
                    REG_PERIOD: n_reload  = period_of(i_item.write_byte[3:0]);
                    REG_LENGTH: n_len     = length_of(i_item.write_byte[7:3]);
                    default:    n_restart = r_restart;
                endcase
            end
            CMD_TIMER: begin
                if (r_count == '0) begin
                    n_count = r_reload;
                    n_lfsr  = {r_lfsr[0] ^ w_tap, r_lfsr[14:1]};
                end else begin
                    n_count = r_count - 12'd1;
                end
            end
            CMD_ENV: begin
                if (r_restart) begin
                    n_restart   = 1'b0;
                    n_env_level = LEVEL_MAX;
                    n_env_count = w_vol;
                end else if (r_env_count != '0) begin
                    n_env_count = r_env_count - 4'd1;
                end else begin
                    n_env_count = w_vol;
                    if (r_env_level != '0) begin
                        n_env_level = r_env_level - 4'd1;
                    end else if (w_halt) begin
                        n_env_level = LEVEL_MAX;
                    end
                end
            end
            CMD_LENGTH: begin
                if (!w_halt && r_len != '0) begin
                    n_len = r_len - 8'd1;
                end
            end
            default: n_len = r_len;
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                r_regs[i] <= '0;
            end
            r_reload    <= '0;
            r_count     <= '0;
            r_lfsr      <= LFSR_SEED;
            r_len       <= '0;
            r_restart   <= 1'b0;
            r_env_level <= '0;
            r_env_count <= '0;
        end else if (i_en) begin
            r_regs      <= n_regs;
            r_reload    <= n_reload;
            r_count     <= n_count;
            r_lfsr      <= n_lfsr;
            r_len       <= n_len;
            r_restart   <= n_restart;
            r_env_level <= n_env_level;
            r_env_count <= n_env_count;
        end
    end

    // gating on the updated state
    assign w_mute = (n_len == '0) || (n_reload < PERIOD_MIN) || n_lfsr[0];
    assign o_amplitude = w_mute ? 4'd0
                       : (n_regs[REG_CTRL][4] ? n_regs[REG_CTRL][3:0] : n_env_level);

endmodule

/* rtl/lfsr_noise_channel.sv */
// Noise channel of a sound chip.
// i_in carries one command item: cmd (write, timer tick, envelope tick,
// length tick), reg_select and write_byte. o_out returns one item per
// command, the 4-bit amplitude after the command has taken effect.
// Both channels use valid/ready; an item moves when both are high.
// An accepted item waits in the input register, then the state update and
// gating logic feed the result register. Throughput is one item per cycle
// while the receiver does not stall; the state update (timer, lfsr shift,
// envelope, length counter) is combinational, so it never holds the flow.
// Reset clears the registers, counters and envelope, seeds the lfsr with
// one and empties both stages; i_in.ready is low while reset is held.
// When the receiver stalls, the result register holds its item and the
// input register takes one more item; further items wait on i_in.ready.
// The channel state advances only as an item enters the result register.
module lfsr_noise_channel import lnc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lnc_in_if.sink     i_in,
    lnc_out_if.source  o_out
);

    logic       w_stage_valid;
    t_item      w_stage_item;
    logic       w_take;
    logic       w_fire;
    logic [3:0] w_amplitude;
    logic       r_out_valid;
    logic       n_out_valid;
    logic [3:0] r_amplitude;

    assign w_take = !r_out_valid || o_out.ready;
    assign w_fire = w_stage_valid && w_take;

    lnc_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_take  (w_take),
        .o_valid (w_stage_valid),
        .o_item  (w_stage_item)
    );

    lnc_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_fire),
        .i_item      (w_stage_item),
        .o_amplitude (w_amplitude)
    );

    // result register
    always_comb begin
        n_out_valid = r_out_valid;
        if (w_fire) begin
            n_out_valid = 1'b1;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_amplitude <= w_amplitude;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.amplitude = r_amplitude;

endmodule

/* rtl/lnc_checker.sv */
module lnc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [3:0] i_out_amplitude
);

    // a waiting result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result item dropped while stalled");

    // a waiting result keeps its value
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_amplitude))
        else $error("result item changed while stalled");

    // reset leaves no result behind and takes no item
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !i_out_valid && !(i_in_ready && !i_rst_n))
        else $error("stage not empty after reset");

    // an accepted item is followed by a result on the output unless reset cuts in
    a_latency: assert property (@(posedge i_clk)
        i_in_valid && i_in_ready && i_rst_n ##1 i_rst_n |=> i_out_valid)
        else $error("accepted item produced no result");

endmodule

bind lfsr_noise_channel lnc_checker u_lnc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in.valid),
    .i_in_ready      (i_in.ready),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_out_amplitude (o_out.amplitude)
);
